// ----- hw/rtl/fmp_pkg.sv -----
// Shared constants and types for the Fibonacci-mod-Pisano block.
package fmp_pkg;

  localparam int MOD_WIDTH_DEF   = 10;
  localparam int INDEX_WIDTH_DEF = 63;

  // Seed pair of the Fibonacci walk; the period ends when it comes back.
  localparam int SEED_A = 0;
  localparam int SEED_B = 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PERIOD,
    ST_MODR,
    ST_WALK
  } fmp_state_t;

endpackage

// ----- hw/rtl/fibonacci_mod_pisano_top.sv -----
// Top level: F(n) mod m through the Pisano period, on one shared mod-m step unit.
//
// A transaction is taken at a rising edge with start high and busy low; it
// carries a position in_index_n and a modulus in_modulus. The answer
// F(n) mod m appears on out_remainder for exactly one cycle with out_valid
// high, and the receiver cannot stall it. A modulus of 0 or 1 answers 0 in
// the cycle after acceptance. For m >= 2 the block runs three phases: it
// steps the Fibonacci pair mod m from (0,1) until (0,1) recurs; the step
// count p (the Pisano period) is at most 6m, capped at 6*2^MOD_WIDTH. It
// then reduces n mod p by restoring division, one index bit per cycle;
// finally it steps again from (0,1) n mod p times and delivers the result.
// A single mod-m adder does one Fibonacci step per cycle in both walks. For
// m >= 2, busy is high from acceptance until the result strobe; for m of 0
// or 1 it stays low; a new transaction may be started in the cycle the
// strobe shows.
module fibonacci_mod_pisano_top #(
  parameter int MOD_WIDTH   = fmp_pkg::MOD_WIDTH_DEF,
  parameter int INDEX_WIDTH = fmp_pkg::INDEX_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [INDEX_WIDTH-1:0] in_index_n,
  input  logic [MOD_WIDTH-1:0]   in_modulus,
  output logic                   out_valid,
  output logic [MOD_WIDTH-1:0]   out_remainder
);
  import fmp_pkg::*;

  // Step counter and period: 6*2^MOD_WIDTH fits in MOD_WIDTH+3 bits.
  localparam int CNT_W = MOD_WIDTH + 3;
  localparam int REM_W = CNT_W + 1;
  localparam int BIT_W = $clog2(INDEX_WIDTH);
  localparam logic [CNT_W-1:0] WALK_CAP = CNT_W'(6) << MOD_WIDTH;
  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(INDEX_WIDTH - 1);
  localparam logic [MOD_WIDTH-1:0] SEED_A_V = MOD_WIDTH'(SEED_A);
  localparam logic [MOD_WIDTH-1:0] SEED_B_V = MOD_WIDTH'(SEED_B);

  fmp_state_t             state_r, state_nxt;
  logic [MOD_WIDTH-1:0]   m_r, m_nxt;
  logic [MOD_WIDTH-1:0]   a_r, a_nxt;
  logic [MOD_WIDTH-1:0]   b_r, b_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;    // period steps, then walk count
  logic [CNT_W-1:0]       p_r, p_nxt;
  logic [CNT_W-1:0]       rem_r, rem_nxt;
  logic [INDEX_WIDTH-1:0] n_r, n_nxt;
  logic [BIT_W-1:0]       bit_r, bit_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [MOD_WIDTH-1:0]   out_rem_r, out_rem_nxt;

  // Shared step unit: c = (a + b) mod m, both terms already below m.
  logic [MOD_WIDTH:0]   step_sum;
  logic [MOD_WIDTH:0]   step_red;
  logic [MOD_WIDTH-1:0] step_c;

  always_comb begin
    step_sum = {1'b0, a_r} + {1'b0, b_r};
    step_red = step_sum - {1'b0, m_r};
    step_c   = (step_sum >= {1'b0, m_r}) ? step_red[MOD_WIDTH-1:0]
                                         : step_sum[MOD_WIDTH-1:0];
  end

  // Restoring-division slice: bring down one index bit, subtract p if it fits.
  logic [REM_W-1:0] div_shift;
  logic [REM_W-1:0] div_diff;
  logic [CNT_W-1:0] div_next;

  always_comb begin
    div_shift = {rem_r, n_r[INDEX_WIDTH-1]};
    div_diff  = div_shift - {1'b0, p_r};
    div_next  = (div_shift >= {1'b0, p_r}) ? div_diff[CNT_W-1:0]
                                           : div_shift[CNT_W-1:0];
  end

  logic [CNT_W-1:0] cnt_inc;
  assign cnt_inc = cnt_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and datapath registers carry no reset.
  always_ff @(posedge clk) begin
    m_r       <= m_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    cnt_r     <= cnt_nxt;
    p_r       <= p_nxt;
    rem_r     <= rem_nxt;
    n_r       <= n_nxt;
    bit_r     <= bit_nxt;
    out_rem_r <= out_rem_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    m_nxt         = m_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    cnt_nxt       = cnt_r;
    p_nxt         = p_r;
    rem_nxt       = rem_r;
    n_nxt         = n_r;
    bit_nxt       = bit_r;
    out_valid_nxt = 1'b0;
    out_rem_nxt   = out_rem_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          m_nxt   = in_modulus;
          n_nxt   = in_index_n;
          a_nxt   = SEED_A_V;
          b_nxt   = SEED_B_V;
          cnt_nxt = '0;
          if (in_modulus < MOD_WIDTH'(2)) begin
            // Everything is 0 mod 1; modulus zero answers 0 as well.
            out_valid_nxt = 1'b1;
            out_rem_nxt   = '0;
          end else begin
            state_nxt = ST_PERIOD;
          end
        end
      end

      ST_PERIOD: begin
        // Advance the pair and count until the seed pair recurs or the count hits the cap.
        a_nxt   = b_r;
        b_nxt   = step_c;
        cnt_nxt = cnt_inc;
        if ((b_r == SEED_A_V && step_c == SEED_B_V) || cnt_inc == WALK_CAP) begin
          p_nxt     = cnt_inc;
          rem_nxt   = '0;
          bit_nxt   = LAST_BIT;
          state_nxt = ST_MODR;
        end
      end

      ST_MODR: begin
        rem_nxt = div_next;
        n_nxt   = n_r << 1;
        bit_nxt = bit_r - BIT_W'(1);
        if (bit_r == '0) begin
          cnt_nxt   = div_next;
          a_nxt     = SEED_A_V;
          b_nxt     = SEED_B_V;
          state_nxt = ST_WALK;
        end
      end

      ST_WALK: begin
        if (cnt_r == '0) begin
          out_valid_nxt = 1'b1;
          out_rem_nxt   = a_r;
          state_nxt     = ST_IDLE;
        end else begin
          a_nxt   = b_r;
          b_nxt   = step_c;
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_remainder = out_rem_r;

  // Both walks keep the pair reduced below the modulus.
  a_pair_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PERIOD || state_r == ST_WALK) |-> (a_r < m_r && b_r < m_r))
    else $error("Fibonacci pair not reduced mod m");

  // The partial remainder stays below the period during division.
  a_rem_below_p: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MODR |-> (p_r != '0 && rem_r < p_r))
    else $error("division remainder out of range");

  // The walk count taken from the division never reaches the period.
  a_walk_below_p: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> cnt_r < p_r)
    else $error("walk count exceeds period");

  // An accepted transaction either starts work or answers at once.
  a_start_effect: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted transaction dropped");

  // A delivered result is reduced mod m.
  a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && m_r >= MOD_WIDTH'(2)) |-> out_remainder < m_r)
    else $error("result not reduced mod m");

endmodule

// ----- sim/fmp_checker.sv -----
`timescale 1ns / 100ps
// Checker for the Fibonacci-mod-Pisano block: predicts each remainder and compares results.
module fmp_checker #(
  parameter int MOD_WIDTH   = fmp_pkg::MOD_WIDTH_DEF,
  parameter int INDEX_WIDTH = fmp_pkg::INDEX_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   busy,
  input  logic [INDEX_WIDTH-1:0] in_index_n,
  input  logic [MOD_WIDTH-1:0]   in_modulus,
  input  logic                   out_valid,
  input  logic [MOD_WIDTH-1:0]   out_remainder,
  output int                     mismatches,
  output int                     pending,
  output int                     queries_seen,
  output int                     small_mod_seen,
  output int                     results_seen
);

  typedef struct {
    logic [INDEX_WIDTH-1:0] index_n;
    logic [MOD_WIDTH-1:0]   modulus;
    logic [MOD_WIDTH-1:0]   remainder;
  } fib_query_t;

  fib_query_t expected_remainders[$];

  // F(n) mod m: find the Pisano period, then step n mod period times from the seed.
  function automatic logic [MOD_WIDTH-1:0] fib_mod_m(logic [INDEX_WIDTH-1:0] n,
                                                      logic [MOD_WIDTH-1:0] m);
    int unsigned     mm;
    int unsigned     a;
    int unsigned     b;
    int unsigned     c;
    int unsigned     period;
    int unsigned     walk_cap;
    longint unsigned steps;
    longint unsigned i;
    mm = m;
    if (mm < 2) return '0;
    walk_cap = 6 << MOD_WIDTH;
    a = fmp_pkg::SEED_A;
    b = fmp_pkg::SEED_B;
    period = 0;
    do begin
      c = (a + b) % mm;
      a = b;
      b = c;
      period++;
    end while (!(a == fmp_pkg::SEED_A && b == fmp_pkg::SEED_B) && period < walk_cap);
    steps = longint'(n) % longint'(period);
    a = fmp_pkg::SEED_A;
    b = fmp_pkg::SEED_B;
    for (i = 0; i < steps; i++) begin
      c = (a + b) % mm;
      a = b;
      b = c;
    end
    return a[MOD_WIDTH-1:0];
  endfunction

  assign pending = expected_remainders.size();

  // Retire the result first: a new query can be taken at the edge that ends the strobe.
  always @(posedge clk) begin
    fib_query_t q;
    if (!rst_n) begin
      mismatches     <= 0;
      queries_seen   <= 0;
      small_mod_seen <= 0;
      results_seen   <= 0;
    end else begin
      if (out_valid) begin
        results_seen <= results_seen + 1;
        if (expected_remainders.size() == 0) begin
          $error("remainder %0d arrived with no query waiting", out_remainder);
          mismatches <= mismatches + 1;
        end else begin
          q = expected_remainders.pop_front();
          if (out_remainder !== q.remainder) begin
            $error("remainder mismatch (n=%0d m=%0d): expected %0d, actual %0d",
                   q.index_n, q.modulus, q.remainder, out_remainder);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (start && !busy) begin
        q.index_n   = in_index_n;
        q.modulus   = in_modulus;
        q.remainder = fib_mod_m(in_index_n, in_modulus);
        expected_remainders.insert(expected_remainders.size(), q);
        queries_seen <= queries_seen + 1;
        if (in_modulus < 2) small_mod_seen <= small_mod_seen + 1;
      end
    end
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench top: drives queries into the Fibonacci-mod-Pisano block and gives the verdict.
module tb_top;

  localparam int MOD_W     = fmp_pkg::MOD_WIDTH_DEF;
  localparam int IDX_W     = fmp_pkg::INDEX_WIDTH_DEF;
  localparam int RAND_QUERIES = 80;
  // Longest legal silence is one query at the largest modulus plus a sender
  // gap; the limit leaves a wide margin above that before declaring the block
  // hung.
  localparam int WATCHDOG_LIMIT = 60000;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [IDX_W-1:0] in_index_n;
  logic [MOD_W-1:0] in_modulus;
  logic             out_valid;
  logic [MOD_W-1:0] out_remainder;

  int mismatches;
  int pending;
  int queries_seen;
  int small_mod_seen;
  int results_seen;
  int quiet_cycles;

  fibonacci_mod_pisano_top #(
    .MOD_WIDTH  (MOD_W),
    .INDEX_WIDTH(IDX_W)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_index_n   (in_index_n),
    .in_modulus   (in_modulus),
    .out_valid    (out_valid),
    .out_remainder(out_remainder)
  );

  fmp_checker #(
    .MOD_WIDTH  (MOD_W),
    .INDEX_WIDTH(IDX_W)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_index_n    (in_index_n),
    .in_modulus    (in_modulus),
    .out_valid     (out_valid),
    .out_remainder (out_remainder),
    .mismatches    (mismatches),
    .pending       (pending),
    .queries_seen  (queries_seen),
    .small_mod_seen(small_mod_seen),
    .results_seen  (results_seen)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Count cycles where neither channel moves a transaction; give up at the limit.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               quiet_cycles, pending);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one query at the current falling edge and hold it until the block
  // takes it. busy only moves at rising edges, so its value at a falling edge
  // is the one the next rising edge sees. Return at a falling edge with start
  // still high, so back-to-back queries never lower and raise it in one step.
  task automatic send_query(input logic [IDX_W-1:0] n, input logic [MOD_W-1:0] m);
    start      <= 1'b1;
    in_index_n <= n;
    in_modulus <= m;
    while (busy) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
  endtask

  // Drop start for the given number of cycles; gaps land on whatever phase the block is in.
  task automatic idle_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Hold off until every outstanding remainder has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    logic [IDX_W-1:0] n;
    logic [MOD_W-1:0] m;
    logic [IDX_W-1:0] all_ones;
    all_ones     = '1;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_index_n   = '0;
    in_modulus   = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: modulus zero and one short-circuit, tiny moduli, the widest
    // modulus, index extremes, and an index that is a whole period.
    send_query('0, '0);
    send_query(all_ones, '0);
    send_query(IDX_W'(5), MOD_W'(1));
    send_query(all_ones, MOD_W'(1));
    send_query('0, MOD_W'(2));
    send_query(IDX_W'(1), MOD_W'(2));
    send_query(IDX_W'(2), MOD_W'(2));
    send_query(IDX_W'(3), MOD_W'(2));
    send_query(IDX_W'(8), MOD_W'(3));
    send_query(IDX_W'(7), MOD_W'(3));
    send_query(IDX_W'(10), MOD_W'(10));
    send_query(IDX_W'(1500), MOD_W'(1000));
    send_query(IDX_W'(1499), MOD_W'(1000));
    send_query('0, MOD_W'(1023));
    send_query(IDX_W'(1), MOD_W'(1023));
    send_query(all_ones, MOD_W'(1023));
    send_query(all_ones, MOD_W'(512));
    send_query(all_ones - 1, MOD_W'(1022));
    send_query({1'b1, {(IDX_W-1){1'b0}}}, MOD_W'(5));
    send_query(IDX_W'(90), MOD_W'(1));

    // Let everything settle before the random part.
    drain_results();

    for (int i = 0; i < RAND_QUERIES; i++) begin
      // Keep most moduli small: period, and with it latency, grows with m.
      case ($urandom_range(0, 9))
        0:       m = MOD_W'($urandom_range(0, 1));
        1, 2, 3,
        4, 5:    m = MOD_W'($urandom_range(2, 63));
        6, 7, 8: m = MOD_W'($urandom_range(64, 1023));
        default: m = MOD_W'($urandom_range(1000, 1023));
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2: n = IDX_W'($urandom_range(0, 200));
        3:       n = all_ones - IDX_W'($urandom_range(0, 15));
        default: n = {$urandom, $urandom};
      endcase
      send_query(n, m);
      // Idle about 18% of the time, with a calm stretch in the middle.
      if (i < 30 || i >= 50) begin
        if ($urandom_range(0, 99) < 18) begin
          if ($urandom_range(0, 9) == 0) idle_sender($urandom_range(5, 40));
          else                           idle_sender($urandom_range(1, 4));
        end
        if ($urandom_range(0, 99) < 3) drain_results();
      end
    end

    drain_results();
    repeat (10) @(negedge clk);

    $display("Covered %0d queries (%0d with modulus below two) and checked %0d remainders.",
             queries_seen, small_mod_seen, results_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- fibonacci_mod_pisano_top.f -----
hw/rtl/fmp_pkg.sv
hw/rtl/fibonacci_mod_pisano_top.sv
sim/fmp_checker.sv
sim/tb_top.sv
